// ===== rtl/table_interpolation_linearizer_assert.svh =====
// assertion macros for the linearizer
`ifndef TABLE_INTERPOLATION_LINEARIZER_ASSERT_SVH
`define TABLE_INTERPOLATION_LINEARIZER_ASSERT_SVH

// consequent in the same cycle
`define TIL_ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the next cycle
`define TIL_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tilin_pkg.sv =====
`default_nettype none

package tilin_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 32;

  localparam int OHMS_W = 20;
  localparam int DEG_W  = 16;
  localparam int FRAC_W = 8;
  localparam int TEMP_W = DEG_W + FRAC_W;
  localparam int PROD_W = DEG_W + OHMS_W;
  localparam int SLOT_W = 5;
  localparam int CFG_W  = 6;
  localparam int RAM_W  = OHMS_W + DEG_W;

  localparam int DIV_STEPS = TEMP_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_CONVERT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAST,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } tilin_state_t;

endpackage

`default_nettype wire

// ===== rtl/tilin_ram.sv =====
`default_nettype none

module tilin_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/table_interpolation_linearizer.sv =====
// Piecewise-linear temperature linearizer over a loadable table of up to TABLE_DEPTH
// (resistance, temperature) points held in one synchronous RAM. A load request writes
// one entry. A convert request reads the last entry in use for the range check, then
// scans the table from entry zero at one entry per cycle through the RAM's single read
// port, and, when the sample falls between two entries, runs one 16x20 multiply
// followed by a 24-step restoring divide at one quotient bit per cycle. Each convert
// ends in the output state, which writes the result into the output register once that
// register is free, and the FSM then returns to idle for the next request. A sample
// above the last entry skips the scan, and zero entries in use skip both the range
// check and the scan. Input stalls while a convert is at work and while its result
// waits for a stalled output register; a finished result sits in the output register
// and the next request is taken meanwhile.
// Table entries are undefined until loaded and have no clearing pass.
`default_nettype none
`include "table_interpolation_linearizer_assert.svh"

module table_interpolation_linearizer #(
  parameter int TABLE_DEPTH = tilin_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,

  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tilin_pkg::CFG_W-1:0]       cfg_data,

  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              action,
  input  wire logic [tilin_pkg::SLOT_W-1:0]      entry_slot,
  input  wire logic [tilin_pkg::OHMS_W-1:0]      entry_ohms,
  input  wire logic signed [tilin_pkg::DEG_W-1:0] entry_degrees,
  input  wire logic [tilin_pkg::OHMS_W-1:0]      sample_ohms,

  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [tilin_pkg::TEMP_W-1:0]    temperature,
  output logic                                   in_range
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  tilin_pkg::tilin_state_t state, state_next;

  logic [tilin_pkg::CFG_W-1:0]  entries_in_use;

  logic [tilin_pkg::OHMS_W-1:0] x;
  logic [CW-1:0]                n;
  logic [IW-1:0]                k;
  logic [tilin_pkg::OHMS_W-1:0] r1;
  logic signed [tilin_pkg::DEG_W-1:0] t1;
  logic signed [tilin_pkg::DEG_W:0]   dt;
  logic [tilin_pkg::OHMS_W-1:0] dx;
  logic [tilin_pkg::OHMS_W-1:0] dsor;
  logic [tilin_pkg::OHMS_W-1:0] rem;
  logic [tilin_pkg::TEMP_W-1:0] dsr;
  logic                         neg;
  logic [tilin_pkg::DIV_CNT_W-1:0] cnt;
  logic [tilin_pkg::TEMP_W-1:0] res_temp;
  logic                         res_ok;

  logic                         in_accept;
  logic                         is_convert;
  logic [CW-1:0]                n_clamp;
  logic                         k_last;
  logic                         out_free;

  logic                         ram_we;
  logic [IW-1:0]                ram_waddr;
  logic [IW-1:0]                ram_raddr;
  logic [tilin_pkg::RAM_W-1:0]  ram_rdata;
  logic [tilin_pkg::OHMS_W-1:0] rd_ohms;
  logic signed [tilin_pkg::DEG_W-1:0] rd_deg;

  logic [tilin_pkg::DEG_W-1:0]  mag;
  logic [tilin_pkg::PROD_W-1:0] prod;
  logic [tilin_pkg::OHMS_W:0]   rem_sh;
  logic [tilin_pkg::OHMS_W+1:0] sub;
  logic                         ge;
  logic [tilin_pkg::TEMP_W-1:0] q_signed;

  assign cfg_ready  = 1'b1;
  assign in_accept  = in_valid && !in_stall;
  assign is_convert = (action == tilin_pkg::ACT_CONVERT);
  assign out_free   = !out_valid || !out_stall;

  assign n_clamp = (32'(entries_in_use) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                            : CW'(entries_in_use);
  assign k_last  = ((CW'(k) + CW'(1)) == n);

  assign ram_we    = in_accept && (action == tilin_pkg::ACT_LOAD)
                     && (32'(entry_slot) < 32'(TABLE_DEPTH));
  assign ram_waddr = IW'(entry_slot);
  assign rd_ohms   = ram_rdata[tilin_pkg::OHMS_W-1:0];
  assign rd_deg    = signed'(ram_rdata[tilin_pkg::RAM_W-1:tilin_pkg::OHMS_W]);

  tilin_ram #(
    .WIDTH(tilin_pkg::RAM_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({entry_degrees, entry_ohms}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // divider datapath
  assign mag      = tilin_pkg::DEG_W'(dt[tilin_pkg::DEG_W] ? -dt : dt);
  assign prod     = tilin_pkg::PROD_W'(mag) * tilin_pkg::PROD_W'(dx);
  assign rem_sh   = {rem, dsr[tilin_pkg::TEMP_W-1]};
  assign sub      = {1'b0, rem_sh} - {2'b00, dsor};
  assign ge       = !sub[tilin_pkg::OHMS_W+1];
  assign q_signed = neg ? -dsr : dsr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tilin_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_raddr  = '0;
    in_stall   = 1'b1;
    case (state)
      tilin_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        ram_raddr = IW'(n_clamp - CW'(1));
        if (in_valid && is_convert) begin
          state_next = (n_clamp == '0) ? tilin_pkg::ST_OUT : tilin_pkg::ST_LAST;
        end
      end
      tilin_pkg::ST_LAST: begin
        ram_raddr  = '0;
        state_next = (x > rd_ohms) ? tilin_pkg::ST_OUT : tilin_pkg::ST_SCAN;
      end
      tilin_pkg::ST_SCAN: begin
        ram_raddr = k + IW'(1);
        if (rd_ohms > x) begin
          if (k == '0 || x == r1) begin
            state_next = tilin_pkg::ST_OUT;
          end else begin
            state_next = tilin_pkg::ST_MUL;
          end
        end else if (k_last) begin
          state_next = tilin_pkg::ST_OUT;
        end
      end
      tilin_pkg::ST_MUL: begin
        state_next = tilin_pkg::ST_DIV;
      end
      tilin_pkg::ST_DIV: begin
        if (cnt == tilin_pkg::DIV_CNT_W'(tilin_pkg::DIV_STEPS - 1)) begin
          state_next = tilin_pkg::ST_FIN;
        end
      end
      tilin_pkg::ST_FIN: begin
        state_next = tilin_pkg::ST_OUT;
      end
      tilin_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = tilin_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tilin_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      tilin_pkg::ST_IDLE: begin
        if (in_accept && is_convert) begin
          x        <= sample_ohms;
          n        <= n_clamp;
          k        <= '0;
          res_temp <= '0;
          res_ok   <= 1'b0;
        end
      end
      tilin_pkg::ST_SCAN: begin
        if (rd_ohms > x) begin
          if (k != '0) begin
            if (x == r1) begin
              res_temp <= {t1, {tilin_pkg::FRAC_W{1'b0}}};
              res_ok   <= 1'b1;
            end else begin
              dt   <= {rd_deg[tilin_pkg::DEG_W-1], rd_deg} - {t1[tilin_pkg::DEG_W-1], t1};
              dx   <= x - r1;
              dsor <= rd_ohms - r1;
            end
          end
        end else begin
          r1 <= rd_ohms;
          t1 <= rd_deg;
          k  <= k + IW'(1);
          if (k_last) begin
            res_temp <= {rd_deg, {tilin_pkg::FRAC_W{1'b0}}};
            res_ok   <= 1'b1;
          end
        end
      end
      tilin_pkg::ST_MUL: begin
        rem <= prod[tilin_pkg::PROD_W-1:tilin_pkg::DEG_W];
        dsr <= {prod[tilin_pkg::DEG_W-1:0], {tilin_pkg::FRAC_W{1'b0}}};
        neg <= dt[tilin_pkg::DEG_W];
        cnt <= '0;
      end
      tilin_pkg::ST_DIV: begin
        rem <= ge ? sub[tilin_pkg::OHMS_W-1:0] : rem_sh[tilin_pkg::OHMS_W-1:0];
        dsr <= {dsr[tilin_pkg::TEMP_W-2:0], ge};
        cnt <= cnt + tilin_pkg::DIV_CNT_W'(1);
      end
      tilin_pkg::ST_FIN: begin
        res_temp <= {t1, {tilin_pkg::FRAC_W{1'b0}}} + q_signed;
        res_ok   <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= tilin_pkg::CFG_W'(32);
    end else if (cfg_valid && cfg_ready) begin
      entries_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == tilin_pkg::ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tilin_pkg::ST_OUT && out_free) begin
      temperature <= signed'(res_temp);
      in_range    <= res_ok;
    end
  end

  `TIL_ASSERT_SAME(a_invalid_is_zero, clk, rst, out_valid && !in_range,
    temperature == '0, "out of range result with nonzero temperature")

  `TIL_ASSERT_SAME(a_divisor_nonzero, clk, rst, state == tilin_pkg::ST_DIV,
    dsor != '0, "interpolation divisor is zero")

  `TIL_ASSERT_SAME(a_scan_in_bounds, clk, rst, state == tilin_pkg::ST_SCAN,
    CW'(k) < n, "table scan beyond entries in use")

  `TIL_ASSERT_NEXT(a_convert_starts, clk, rst, in_accept && is_convert,
    state == tilin_pkg::ST_LAST || state == tilin_pkg::ST_OUT,
    "convert request did not start a lookup")

endmodule

`default_nettype wire

// ===== tb/tb_table_interpolation_linearizer.sv =====
`timescale 1ns / 100ps

module tb_table_interpolation_linearizer;

  localparam int DEPTH = tilin_pkg::TABLE_DEPTH_DEFAULT;
  localparam int OHMS_MAX = (1 << tilin_pkg::OHMS_W) - 1;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 135;
  localparam int SETTLE = 80;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic act;
    logic [tilin_pkg::SLOT_W-1:0] slot;
    logic [tilin_pkg::OHMS_W-1:0] ohms;
    logic signed [tilin_pkg::DEG_W-1:0] deg;
    logic [tilin_pkg::OHMS_W-1:0] sample;
  } lin_req_t;

  typedef struct packed {
    logic signed [tilin_pkg::TEMP_W-1:0] temp;
    logic ok;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tilin_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = tilin_pkg::ACT_LOAD;
  logic [tilin_pkg::SLOT_W-1:0] entry_slot = '0;
  logic [tilin_pkg::OHMS_W-1:0] entry_ohms = '0;
  logic signed [tilin_pkg::DEG_W-1:0] entry_degrees = '0;
  logic [tilin_pkg::OHMS_W-1:0] sample_ohms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [tilin_pkg::TEMP_W-1:0] temperature;
  logic in_range;

  table_interpolation_linearizer dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .entry_slot(entry_slot),
    .entry_ohms(entry_ohms),
    .entry_degrees(entry_degrees),
    .sample_ohms(sample_ohms),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .temperature(temperature),
    .in_range(in_range)
  );

  // predictor state
  logic [tilin_pkg::OHMS_W-1:0] ohm_tab [DEPTH];
  logic signed [tilin_pkg::DEG_W-1:0] deg_tab [DEPTH];
  logic [tilin_pkg::CFG_W-1:0] used_entries = tilin_pkg::CFG_W'(32);

  lin_req_t req_queue [$];
  reading_t temps_due [$];
  int gen_ohms [DEPTH];

  logic send_calm = 1'b0;
  logic recv_calm = 1'b0;
  int hold_ask = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int send_wait = 0;
  int recv_wait = 0;
  int idle_cycles = 0;

  int mismatches = 0;
  int results_checked = 0;
  int in_range_seen = 0;
  int loads_seen = 0;
  int cfg_writes = 0;

  logic [tilin_pkg::CFG_W-1:0] phase_cfg [PHASES] = '{32, 1, 0, 63, 2, 17, 40, 5, 32, 9, 24, 3};

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic reading_t lookup_temperature(input logic [tilin_pkg::OHMS_W-1:0] x);
    reading_t r;
    int n;
    int k;
    int pos;
    longint span;
    longint lift;
    longint full;
    r.temp = '0;
    r.ok = 1'b0;
    n = (used_entries > DEPTH) ? DEPTH : int'(used_entries);
    if (n == 0) return r;
    if (x < ohm_tab[0] || x > ohm_tab[n-1]) return r;
    pos = 0;
    for (k = 0; k < n && ohm_tab[k] <= x; k++) pos = k;
    if (x == ohm_tab[pos] || pos + 1 >= n) begin
      full = longint'(deg_tab[pos]) * 256;
    end else begin
      span = longint'(ohm_tab[pos+1]) - longint'(ohm_tab[pos]);
      lift = (longint'(deg_tab[pos+1]) - longint'(deg_tab[pos]))
             * (longint'(x) - longint'(ohm_tab[pos])) * 256;
      full = longint'(deg_tab[pos]) * 256 + lift / span;
    end
    r.temp = full[tilin_pkg::TEMP_W-1:0];
    r.ok = 1'b1;
    return r;
  endfunction

  task automatic queue_load(input int s, input int o, input int d);
    lin_req_t q;
    q.act = tilin_pkg::ACT_LOAD;
    q.slot = tilin_pkg::SLOT_W'(s);
    q.ohms = tilin_pkg::OHMS_W'(o);
    q.deg = tilin_pkg::DEG_W'(d);
    q.sample = tilin_pkg::OHMS_W'($urandom);
    gen_ohms[s] = o;
    req_queue.push_back(q);
  endtask

  task automatic queue_convert(input int x);
    lin_req_t q;
    q.act = tilin_pkg::ACT_CONVERT;
    q.slot = tilin_pkg::SLOT_W'($urandom);
    q.ohms = tilin_pkg::OHMS_W'($urandom);
    q.deg = tilin_pkg::DEG_W'($urandom);
    q.sample = tilin_pkg::OHMS_W'(x);
    req_queue.push_back(q);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (req_queue.size() != 0 || in_valid || temps_due.size() != 0);
  endtask

  task automatic write_entries_in_use(input logic [tilin_pkg::CFG_W-1:0] v);
    @(posedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    used_entries = v;
    cfg_writes++;
  endtask

  // driver
  always @(posedge clk) begin
    lin_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (action == tilin_pkg::ACT_LOAD) begin
          ohm_tab[entry_slot] = entry_ohms;
          deg_tab[entry_slot] = entry_degrees;
          loads_seen++;
        end else begin
          temps_due.push_back(lookup_temperature(sample_ohms));
        end
        send_wait = send_calm ? 0 : $urandom_range(0, 9);
      end
      if (!in_valid || !in_stall) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (req_queue.size() > 0) begin
          nxt = req_queue.pop_front();
          action <= nxt.act;
          entry_slot <= nxt.slot;
          entry_ohms <= nxt.ohms;
          entry_degrees <= nxt.deg;
          sample_ohms <= nxt.sample;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (temps_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with no request due: temperature %0d in_range %0b",
                     $time, temperature, in_range);
          mismatches++;
        end else begin
          want = temps_due.pop_front();
          if (temperature !== want.temp || in_range !== want.ok) begin
            if (mismatches < 10)
              $display("%0t: mismatch: expected temperature %0d in_range %0b, got %0d %0b",
                       $time, want.temp, want.ok, temperature, in_range);
            mismatches++;
          end
          results_checked++;
          if (want.ok) in_range_seen++;
        end
        recv_wait = recv_calm ? 0 : $urandom_range(0, 9);
      end
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, temps_due.size());
      $display("tb_table_interpolation_linearizer: done, errors");
      $finish;
    end
  end

  initial begin
    int p, i, n, m, pick, lo, hi, base, step_max, d0, sl, o, s;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: three-entry table with field extremes, then edge cases
    write_entries_in_use(tilin_pkg::CFG_W'(3));
    @(negedge clk);
    queue_load(0, 0, -32768);
    queue_load(1, 500000, 0);
    queue_load(2, OHMS_MAX, 32767);
    queue_convert(0);
    queue_convert(OHMS_MAX);
    queue_convert(250000);
    queue_convert(500000);
    queue_convert(777777);
    queue_load(0, 100, 1234);
    queue_convert(50);
    queue_convert(100);
    queue_load(2, OHMS_MAX - 1, -5);
    queue_convert(OHMS_MAX);
    queue_convert(OHMS_MAX - 1);
    // non-rising table, then repeated resistance
    queue_load(1, 50, 32767);
    queue_convert(75);
    queue_convert(120);
    queue_load(1, 100, -32768);
    queue_convert(100);
    queue_convert(101);
    queue_convert(900000);
    queue_load(31, OHMS_MAX, -1);

    for (p = 0; p < PHASES; p++) begin
      wait_drained();
      repeat (SETTLE) @(negedge clk);
      write_entries_in_use(phase_cfg[p]);
      @(negedge clk);
      send_calm = (p % 4 == 1) || (p % 4 == 3);
      recv_calm = (p % 4 == 2) || (p % 4 == 3);
      n = phase_cfg[p];
      m = (n > DEPTH) ? DEPTH : n;

      // fresh rising table over every entry in use
      base = $urandom_range(0, 200000);
      step_max = (OHMS_MAX - base) / ((m > 0) ? m : 1);
      if ($urandom_range(0, 3) == 0) step_max = 4;
      d0 = int'($urandom_range(0, 20000)) - 10000;
      sl = int'($urandom_range(0, 1200)) - 600;
      pick = $urandom_range(0, 1);
      o = base;
      for (i = 0; i < m; i++) begin
        queue_load(i, o, pick ? int'($urandom_range(0, 65535)) - 32768 : d0 + i * sl);
        o += $urandom_range(1, step_max);
      end

      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 4 && i == PHASE_ITEMS / 2) begin
          wait_drained();
        end
        if ($urandom_range(0, 3) == 0) begin
          s = $urandom_range(0, DEPTH - 1);
          if (s > 0 && s < m - 1 && $urandom_range(0, 9) != 0)
            o = $urandom_range(gen_ohms[s-1], gen_ohms[s+1]);
          else
            o = $urandom_range(0, OHMS_MAX);
          queue_load(s, o, int'($urandom_range(0, 65535)) - 32768);
        end else begin
          pick = $urandom_range(0, 99);
          o = $urandom_range(0, OHMS_MAX);
          if (m > 0 && pick < 15) begin
            o = gen_ohms[$urandom_range(0, m - 1)];
          end else if (m > 1 && pick < 75) begin
            s = $urandom_range(0, m - 2);
            o = $urandom_range(gen_ohms[s], gen_ohms[s+1]);
          end else if (m > 0 && pick < 90) begin
            lo = gen_ohms[0];
            hi = gen_ohms[m-1];
            if (pick < 82 && lo > 0)
              o = $urandom_range(0, lo - 1);
            else if (hi < OHMS_MAX)
              o = $urandom_range(hi + 1, OHMS_MAX);
          end
          queue_convert(o);
        end
      end

      // long output hold while requests keep coming
      if (p == 0 || p == 6) hold_ask = hold_ask + 1;
    end

    wait_drained();
    repeat (SETTLE) @(negedge clk);
    $display("tb_table_interpolation_linearizer: %0d converts checked, %0d in range,",
             results_checked, in_range_seen);
    $display("  %0d loads, %0d entries_in_use writes (0 to 63), %0d mismatches",
             loads_seen, cfg_writes, mismatches);
    if (mismatches == 0 && temps_due.size() == 0) begin
      $display("tb_table_interpolation_linearizer: done, clean");
    end else begin
      $display("tb_table_interpolation_linearizer: done, errors");
    end
    $finish;
  end

endmodule
